// ----- sv/swrl_pkg.sv -----
// package: shared types, codes and constants of the sliding window rate limiter
`timescale 1ns / 1ps

package swrl_pkg;

  localparam int STAMP_DEPTH_DEF   = 128;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 32;

  // admissions per tick at most
  localparam int MaxOut = 16;
  localparam int OutCntW = $clog2(MaxOut + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [6:0]  MAX_REQ_RST  = 7'd10;
  localparam logic [15:0] WINDOW_RST   = 16'd1000;
  localparam logic [6:0]  BURST_RST    = 7'd0;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_REQUEST   = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_RESET_ALL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POL_QUEUE = 2'd0,
    POL_DROP  = 2'd1,
    POL_TRY   = 2'd2
  } policy_e;

  typedef enum logic [2:0] {
    ST_EXECUTED   = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_REFUSED    = 3'd3,
    ST_QUEUE_FULL = 3'd4,
    ST_ACK        = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_REQUESTS   = 2'd0,
    CFG_WINDOW_MS      = 2'd1,
    CFG_BURST_CAPACITY = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CHK,
    S_TICK_CHK,
    S_ADMIT,
    S_REQ,
    S_CLR,
    S_HEAD_RD,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] policy;
    logic [7:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [2:0]  status;
    logic [7:0]  tokens_left;
    logic [4:0]  pending_count;
    logic [15:0] wait_ms;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic stamp_rd;
    logic expire_pop;
    logic admit;
    logic decide;
    logic clear;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  new_op;
    op_e  op;
    logic expire_hit;
    logic can_admit;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/swrl_stream_if.sv -----
// interface: valid/ready channel carrying one item per handshake
`timescale 1ns / 1ps

interface swrl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sliding_window_rate_limiter_core.sv -----
// top level: sliding window log rate limiter core
// Usage:
//   req_if carries one item per handshake: a tick (advances the millisecond
//   clock), a request with its policy and tag, clear pending, or reset all.
//   rsp_if returns the results; last marks the final result of an item.
//   A tick returns zero to sixteen results, every other item exactly one.
//   cfg_we_i/cfg_idx_i/cfg_data_i write max_requests, window_ms and
//   burst_capacity; write them only while the block is idle.
// Timing:
//   req_if.ready is high only while the controller is idle. A tick or a
//   request first drops expired stamps, each with a stamp memory read and
//   then a compare; expiry and the head read before each result share the
//   single stamp memory read port.
//   Results go through one output register; when rsp_if stalls the
//   controller holds in its emit step, and a new item is taken as soon as
//   the last result sits in that register.
// Reset: the clock, both queues and the output register clear at once; the
//   registers return to 10, 1000 and 0. No clearing pass is needed.
`timescale 1ns / 1ps

module sliding_window_rate_limiter_core #(
  parameter int STAMP_DEPTH   = swrl_pkg::STAMP_DEPTH_DEF,
  parameter int PENDING_DEPTH = swrl_pkg::PENDING_DEPTH_DEF,
  parameter int TIME_WIDTH    = swrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swrl_stream_if.sink                   req_if,
  swrl_stream_if.source                 rsp_if,
  input  logic                          cfg_we_i,
  input  logic [swrl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swrl_pkg::CfgDataW-1:0] cfg_data_i
);

  swrl_pkg::cmd_t      cmd;
  swrl_pkg::stat_t     stat;
  swrl_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  swrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swrl_dp #(
    .STAMP_DEPTH   (STAMP_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (req_if.payload),
    .out_ready_i (rsp_if.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign req_if.ready   = in_ready;
  assign rsp_if.valid   = out_valid;
  assign rsp_if.payload = out_item;

endmodule

// ----- sv/swrl_ctrl.sv -----
// controller: state machine sequencing expiry, admission and result output
`timescale 1ns / 1ps

module swrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swrl_pkg::stat_t   stat_i,
  output swrl_pkg::cmd_t    cmd_o
);

  swrl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swrl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.new_op == swrl_pkg::OP_TICK || stat_i.new_op == swrl_pkg::OP_REQUEST) begin
            state_d = swrl_pkg::S_EXP_RD;
          end else begin
            state_d = swrl_pkg::S_CLR;
          end
        end
      end
      swrl_pkg::S_EXP_RD: begin
        cmd_o.stamp_rd = 1'b1;
        state_d        = swrl_pkg::S_EXP_CHK;
      end
      swrl_pkg::S_EXP_CHK: begin
        if (stat_i.expire_hit) begin
          cmd_o.expire_pop = 1'b1;
          state_d          = swrl_pkg::S_EXP_RD;
        end else if (stat_i.op == swrl_pkg::OP_TICK) begin
          state_d = swrl_pkg::S_TICK_CHK;
        end else begin
          state_d = swrl_pkg::S_REQ;
        end
      end
      swrl_pkg::S_TICK_CHK: begin
        state_d = stat_i.can_admit ? swrl_pkg::S_ADMIT : swrl_pkg::S_IDLE;
      end
      swrl_pkg::S_ADMIT: begin
        cmd_o.admit = 1'b1;
        state_d     = swrl_pkg::S_HEAD_RD;
      end
      swrl_pkg::S_REQ: begin
        cmd_o.decide = 1'b1;
        state_d      = swrl_pkg::S_HEAD_RD;
      end
      swrl_pkg::S_CLR: begin
        cmd_o.clear = 1'b1;
        state_d     = swrl_pkg::S_HEAD_RD;
      end
      swrl_pkg::S_HEAD_RD: begin
        cmd_o.stamp_rd = 1'b1;
        state_d        = swrl_pkg::S_EMIT;
      end
      swrl_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.op == swrl_pkg::OP_TICK && stat_i.can_admit) begin
            state_d = swrl_pkg::S_ADMIT;
          end else begin
            state_d = swrl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = swrl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/swrl_dp.sv -----
// datapath: clock, stamp memory, pending queue, limits and output register
`timescale 1ns / 1ps

module swrl_dp #(
  parameter int STAMP_DEPTH   = swrl_pkg::STAMP_DEPTH_DEF,
  parameter int PENDING_DEPTH = swrl_pkg::PENDING_DEPTH_DEF,
  parameter int TIME_WIDTH    = swrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swrl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [swrl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  swrl_pkg::in_item_t              in_item_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output swrl_pkg::out_item_t             out_item_o,
  input  swrl_pkg::cmd_t                  cmd_i,
  output swrl_pkg::stat_t                 stat_o
);

  localparam int SIdxW = $clog2(STAMP_DEPTH);
  localparam int CntW  = $clog2(STAMP_DEPTH + 1);
  localparam int LimW  = (CntW > 8) ? CntW : 8;
  localparam int PIdxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int OccW  = $clog2(PENDING_DEPTH + 1);

  // configuration
  logic [6:0]  max_req_q;
  logic [15:0] window_q;
  logic [6:0]  burst_q;

  // control state
  logic [TIME_WIDTH-1:0]       time_q;
  logic [SIdxW-1:0]            s_head_q;
  logic [CntW-1:0]             cnt_q;
  logic [PIdxW-1:0]            p_head_q;
  logic [OccW-1:0]             occ_q;
  logic [swrl_pkg::OutCntW-1:0] n_q;
  swrl_pkg::op_e               op_q;
  logic                        out_valid_q;

  // payload
  logic [1:0]                  pol_q;
  logic [7:0]                  tag_q;
  swrl_pkg::status_e           status_q;
  logic [TIME_WIDTH-1:0]       rd_data_q;
  swrl_pkg::out_item_t         out_item_q;

  logic [TIME_WIDTH-1:0] stamp_mem [STAMP_DEPTH];
  logic [7:0]            pend_mem  [PENDING_DEPTH];

  logic [6:0]            m_eff;
  logic [15:0]           w_eff;
  logic [LimW-1:0]       lim_sum;
  logic [LimW-1:0]       limit;
  logic [LimW-1:0]       cnt_ext;
  logic [LimW-1:0]       tokens;
  logic                  tok_free;
  logic [TIME_WIDTH-1:0] age;
  logic [15:0]           wait_ms;
  logic                  has_room;
  logic                  rec_en;
  logic                  push_en;
  logic                  pend_full;
  logic [SIdxW-1:0]      s_head_inc;
  logic [SIdxW:0]        s_tail_sum;
  logic [SIdxW-1:0]      s_tail;
  logic [PIdxW-1:0]      p_head_inc;
  logic [PIdxW:0]        p_tail_sum;
  logic [PIdxW-1:0]      p_tail;
  swrl_pkg::status_e     decide_status;

  assign m_eff   = (max_req_q == 7'd0) ? 7'd1 : max_req_q;
  assign w_eff   = (window_q == 16'd0) ? 16'd1 : window_q;
  assign lim_sum = LimW'(m_eff) + LimW'(burst_q);
  assign limit   = (lim_sum > LimW'(STAMP_DEPTH)) ? LimW'(STAMP_DEPTH) : lim_sum;
  assign cnt_ext = LimW'(cnt_q);
  assign tokens  = (cnt_ext >= limit) ? '0 : limit - cnt_ext;
  assign tok_free = (tokens != '0);

  assign age     = time_q - rd_data_q;
  assign wait_ms = (!tok_free && cnt_q != '0 && age < TIME_WIDTH'(w_eff))
                   ? (w_eff - age[15:0]) : 16'd0;

  assign has_room  = (cnt_q < CntW'(STAMP_DEPTH));
  assign pend_full = (occ_q >= OccW'(PENDING_DEPTH));
  assign rec_en    = has_room && (cmd_i.admit || (cmd_i.decide && tok_free));
  assign push_en   = cmd_i.decide && !tok_free && !pend_full &&
                     (swrl_pkg::policy_e'(pol_q) == swrl_pkg::POL_QUEUE);

  assign s_head_inc = (s_head_q == SIdxW'(STAMP_DEPTH - 1)) ? '0 : s_head_q + 1'b1;
  assign s_tail_sum = (SIdxW + 1)'(s_head_q) + (SIdxW + 1)'(cnt_q);
  assign s_tail     = (s_tail_sum >= (SIdxW + 1)'(STAMP_DEPTH))
                      ? SIdxW'(s_tail_sum - (SIdxW + 1)'(STAMP_DEPTH)) : SIdxW'(s_tail_sum);
  assign p_head_inc = (p_head_q == PIdxW'(PENDING_DEPTH - 1)) ? '0 : p_head_q + 1'b1;
  assign p_tail_sum = (PIdxW + 1)'(p_head_q) + (PIdxW + 1)'(occ_q);
  assign p_tail     = (p_tail_sum >= (PIdxW + 1)'(PENDING_DEPTH))
                      ? PIdxW'(p_tail_sum - (PIdxW + 1)'(PENDING_DEPTH)) : PIdxW'(p_tail_sum);

  always_comb begin
    if (tok_free) begin
      decide_status = swrl_pkg::ST_EXECUTED;
    end else begin
      unique case (swrl_pkg::policy_e'(pol_q))
        swrl_pkg::POL_QUEUE: begin
          decide_status = pend_full ? swrl_pkg::ST_QUEUE_FULL : swrl_pkg::ST_QUEUED;
        end
        swrl_pkg::POL_DROP: begin
          decide_status = swrl_pkg::ST_DROPPED;
        end
        default: begin
          decide_status = swrl_pkg::ST_REFUSED;
        end
      endcase
    end
  end

  // stamp memory
  always_ff @(posedge clk_i) begin
    if (rec_en) begin
      stamp_mem[s_tail] <= time_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stamp_rd) begin
      rd_data_q <= stamp_mem[s_head_q];
    end
  end

  // pending queue storage
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      pend_mem[p_tail] <= tag_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pol_q <= in_item_i.policy;
      tag_q <= in_item_i.request_tag;
    end
    if (cmd_i.admit) begin
      tag_q    <= pend_mem[p_head_q];
      status_q <= swrl_pkg::ST_EXECUTED;
    end
    if (cmd_i.decide) begin
      status_q <= decide_status;
    end
    if (cmd_i.clear) begin
      tag_q    <= 8'd0;
      status_q <= swrl_pkg::ST_ACK;
    end
    if (cmd_i.emit) begin
      out_item_q.tag           <= tag_q;
      out_item_q.status        <= status_q;
      out_item_q.tokens_left   <= 8'(tokens);
      out_item_q.pending_count <= 5'(occ_q);
      out_item_q.wait_ms       <= wait_ms;
      out_item_q.last          <= !stat_o.can_admit || (op_q != swrl_pkg::OP_TICK);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q   <= swrl_pkg::MAX_REQ_RST;
      window_q    <= swrl_pkg::WINDOW_RST;
      burst_q     <= swrl_pkg::BURST_RST;
      time_q      <= '0;
      s_head_q    <= '0;
      cnt_q       <= '0;
      p_head_q    <= '0;
      occ_q       <= '0;
      n_q         <= '0;
      op_q        <= swrl_pkg::OP_TICK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (swrl_pkg::cfg_idx_e'(cfg_idx_i))
          swrl_pkg::CFG_MAX_REQUESTS:   max_req_q <= cfg_data_i[6:0];
          swrl_pkg::CFG_WINDOW_MS:      window_q  <= cfg_data_i;
          swrl_pkg::CFG_BURST_CAPACITY: burst_q   <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        op_q <= swrl_pkg::op_e'(in_item_i.operation);
        n_q  <= '0;
        if (swrl_pkg::op_e'(in_item_i.operation) == swrl_pkg::OP_TICK) begin
          time_q <= time_q + 1'b1;
        end
      end
      if (cmd_i.expire_pop) begin
        s_head_q <= s_head_inc;
        cnt_q    <= cnt_q - 1'b1;
      end
      if (rec_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.admit) begin
        p_head_q <= p_head_inc;
        occ_q    <= occ_q - 1'b1;
        n_q      <= n_q + 1'b1;
      end
      if (push_en) begin
        occ_q <= occ_q + 1'b1;
      end
      if (cmd_i.clear) begin
        p_head_q <= '0;
        occ_q    <= '0;
        if (op_q == swrl_pkg::OP_RESET_ALL) begin
          s_head_q <= '0;
          cnt_q    <= '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.new_op     = swrl_pkg::op_e'(in_item_i.operation);
  assign stat_o.op         = op_q;
  assign stat_o.expire_hit = (cnt_q != '0) && (age > TIME_WIDTH'(w_eff));
  assign stat_o.can_admit  = (occ_q != '0) && tok_free &&
                             (n_q < swrl_pkg::OutCntW'(swrl_pkg::MaxOut));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
